// ===== sv/tvi_pkg.sv =====
// Shared types and constants for the voxel integration unit.
// No dependencies.
package tvi_pkg;
  localparam int VOXEL_COUNT = 65536;
  localparam int VOX_AW      = $clog2(VOXEL_COUNT);
  localparam int TSDF_W      = 16;
  localparam int WEIGHT_W    = 16;
  localparam int COLOR_W     = 24;
  localparam int WORD_W      = TSDF_W + WEIGHT_W + COLOR_W;

  localparam logic [TSDF_W-1:0] TSDF_RESET = 16'h7fff;

  localparam logic CFG_TRUNC_MARGIN = 1'b0;
  localparam logic CFG_OBS_WEIGHT   = 1'b1;

  typedef logic [WORD_W-1:0] voxel_word_t;
endpackage

// ===== sv/tvi_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tvi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/tsdf_voxel_integrate_unit.sv =====
// Top level of the TSDF voxel integration unit.
// Depends on tvi_pkg and tvi_ram.
//
// The unit fuses one depth and colour observation into one stored voxel per
// transaction. Voxel state (Q1.15 distance, 8.8 weight, packed colour) lives
// in one 65536-entry synchronous RAM. After reset the unit sweeps the RAM
// once, one entry per cycle, and accepts no input transaction until the
// sweep is done; configuration writes are taken at any time. Items are
// handled one at a time. A voxel that is not fused goes from the input
// through the read, check and output states back to idle. A fused voxel
// uses the single shared restoring divider, which runs 34 steps for each
// of up to five quotients (truncated distance, distance average and three
// colour averages; four when the margin is zero), with a load and a finish
// step per quotient and the multiply states MUL_A and MUL_B per average.
// The result sits in an output register, so the next input transaction is
// accepted while it waits.
module tsdf_voxel_integrate_unit
  import tvi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [VOX_AW-1:0]   voxel_index,
  input  logic signed [15:0]  cam_z,
  input  logic [15:0]         depth_sample,
  input  logic                in_view,
  input  logic [COLOR_W-1:0]  pixel_color,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                updated,
  output logic signed [TSDF_W-1:0] tsdf_value,
  output logic [WEIGHT_W-1:0] weight_value,
  output logic [COLOR_W-1:0]  color_value
);
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_MUL_A  = 4'd4;
  localparam logic [3:0] S_MUL_B  = 4'd5;
  localparam logic [3:0] S_DIV_LD = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_WB     = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  localparam logic [2:0] OP_DIST = 3'd0;
  localparam logic [2:0] OP_TSDF = 3'd1;
  localparam logic [2:0] OP_R    = 3'd2;
  localparam logic [2:0] OP_G    = 3'd3;
  localparam logic [2:0] OP_B    = 3'd4;

  localparam int DIV_N = 34;
  localparam int DIV_D = 18;
  localparam logic [5:0] DIV_LAST = 6'(DIV_N - 1);

  logic [3:0] state;
  logic [2:0] op;

  // Configuration registers.
  logic [11:0] trunc_margin;
  logic [15:0] meas_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      trunc_margin <= 12'd50;
      meas_weight  <= 16'd256;
    end else if (cfg_write) begin
      if (cfg_index == CFG_TRUNC_MARGIN) begin
        trunc_margin <= cfg_data[11:0];
      end else begin
        meas_weight <= cfg_data;
      end
    end
  end

  // Latched input transaction.
  logic [VOX_AW-1:0]  idx;
  logic signed [15:0] z_q;
  logic [15:0]        depth_q;
  logic               view_q;
  logic [COLOR_W-1:0] ncol_q;

  // Old voxel contents and working registers.
  logic signed [15:0] t_old;
  logic [15:0]        w_old;
  logic [COLOR_W-1:0] c_old;
  logic [16:0]        den;
  logic signed [15:0] sdf_obs;
  logic signed [33:0] prod;
  logic signed [34:0] acc;
  logic               neg;
  logic [DIV_N-1:0]   dv_n;
  logic [DIV_D-1:0]   dv_d;
  logic [DIV_D-1:0]   dv_rem;
  logic [5:0]         cnt;

  // Pending result.
  logic               res_upd;
  logic [15:0]        res_t;
  logic [15:0]        res_w;
  logic [COLOR_W-1:0] res_c;

  logic [VOX_AW-1:0] clr_addr;

  // RAM connections.
  logic        ram_we;
  logic [VOX_AW-1:0] ram_waddr;
  voxel_word_t ram_wdata;
  voxel_word_t ram_rdata;

  tvi_ram #(
    .WIDTH(WORD_W),
    .DEPTH(VOXEL_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {res_t, res_w, res_c};
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = {TSDF_RESET, {WEIGHT_W{1'b0}}, {COLOR_W{1'b0}}};
    end else if (state == S_WB) begin
      ram_we = 1'b1;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Fuse test on the latched transaction.
  logic signed [17:0] diff;
  logic signed [18:0] neg_margin;
  logic               fuse;
  logic [15:0]        rd_t;
  logic [15:0]        rd_w;
  logic [16:0]        rd_den;

  assign diff       = $signed({2'b00, depth_q}) - $signed({{2{z_q[15]}}, z_q});
  assign neg_margin = -$signed({7'd0, trunc_margin});
  assign fuse       = view_q && (depth_q != 16'd0)
                      && ($signed({diff[17], diff}) >= neg_margin);
  assign rd_t       = ram_rdata[WORD_W-1 -: TSDF_W];
  assign rd_w       = ram_rdata[COLOR_W +: WEIGHT_W];
  assign rd_den     = {1'b0, rd_w} + {1'b0, meas_weight};

  // Shared multiplier; its operands depend on the step and the operation.
  logic [7:0]         old_byte;
  logic [7:0]         new_byte;
  logic signed [16:0] mul_x;
  logic signed [16:0] mul_y;
  logic signed [33:0] mul_p;

  always_comb begin
    case (op)
      OP_G: begin
        old_byte = c_old[15:8];
        new_byte = ncol_q[15:8];
      end
      OP_B: begin
        old_byte = c_old[23:16];
        new_byte = ncol_q[23:16];
      end
      default: begin
        old_byte = c_old[7:0];
        new_byte = ncol_q[7:0];
      end
    endcase
    if (state == S_MUL_A) begin
      mul_x = $signed({1'b0, w_old});
      mul_y = (op == OP_TSDF) ? $signed({t_old[15], t_old}) : $signed({9'd0, old_byte});
    end else begin
      mul_x = $signed({1'b0, meas_weight});
      mul_y = (op == OP_TSDF) ? $signed({sdf_obs[15], sdf_obs}) : $signed({9'd0, new_byte});
    end
  end

  assign mul_p = mul_x * mul_y;

  // Divider load values: round(n / d) is formed as (2|n| + d) / (2d).
  logic [16:0] dsel;
  logic [32:0] mag;
  assign dsel = (op == OP_DIST) ? {5'd0, trunc_margin} : den;
  assign mag  = acc[34] ? 33'(-acc) : acc[32:0];

  // One restoring divider step.
  logic [DIV_D:0] trial;
  logic           ge;
  assign trial = {dv_rem, dv_n[DIV_N-1]};
  assign ge    = (trial >= {1'b0, dv_d});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      op        <= OP_DIST;
      cnt       <= '0;
    end else begin
      // The output state sets out_valid itself when it is in control of it.
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {VOX_AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            idx     <= voxel_index;
            z_q     <= cam_z;
            depth_q <= depth_sample;
            view_q  <= in_view;
            ncol_q  <= pixel_color;
            state   <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          t_old   <= $signed(rd_t);
          w_old   <= rd_w;
          c_old   <= ram_rdata[COLOR_W-1:0];
          den     <= rd_den;
          res_t   <= rd_t;
          res_w   <= rd_w;
          res_c   <= ram_rdata[COLOR_W-1:0];
          res_upd <= fuse;
          if (!fuse || rd_den == 17'd0) begin
            state <= S_OUT;
          end else begin
            res_w <= rd_den[16] ? 16'hffff : rd_den[15:0];
            if (trunc_margin == 12'd0) begin
              sdf_obs <= (diff > 18'sd0) ? 16'sh7fff : 16'sh0000;
              op      <= OP_TSDF;
              state   <= S_MUL_A;
            end else begin
              acc   <= {{2{diff[17]}}, diff, 15'd0};
              op    <= OP_DIST;
              state <= S_DIV_LD;
            end
          end
        end
        S_MUL_A: begin
          prod  <= mul_p;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          acc   <= {prod[33], prod} + {mul_p[33], mul_p};
          state <= S_DIV_LD;
        end
        S_DIV_LD: begin
          neg    <= acc[34];
          dv_n   <= {mag, 1'b0} + {17'd0, dsel};
          dv_d   <= {dsel, 1'b0};
          dv_rem <= '0;
          cnt    <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          dv_rem <= ge ? DIV_D'(trial - {1'b0, dv_d}) : trial[DIV_D-1:0];
          dv_n   <= {dv_n[DIV_N-2:0], ge};
          cnt    <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // dv_n now holds the rounded magnitude.
          state <= S_MUL_A;
          case (op)
            OP_DIST: begin
              if (neg) begin
                sdf_obs <= $signed(-dv_n[15:0]);
              end else if (dv_n > 34'd32767) begin
                sdf_obs <= 16'sh7fff;
              end else begin
                sdf_obs <= $signed(dv_n[15:0]);
              end
              op <= OP_TSDF;
            end
            OP_TSDF: begin
              res_t <= neg ? -dv_n[15:0] : dv_n[15:0];
              op    <= OP_R;
            end
            OP_R: begin
              res_c[7:0] <= dv_n[7:0];
              op         <= OP_G;
            end
            OP_G: begin
              res_c[15:8] <= dv_n[7:0];
              op          <= OP_B;
            end
            default: begin
              res_c[23:16] <= dv_n[7:0];
              state        <= S_WB;
            end
          endcase
        end
        S_WB: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            updated      <= res_upd;
            tsdf_value   <= $signed(res_t);
            weight_value <= res_w;
            color_value  <= res_c;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
